@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, sampled on clk, off during rst
`define CHK_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("scheduler port check failed");
// next-cycle implication
`define CHK_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("scheduler port check failed");
`endif

@@ hdl/mpcs_pkg.sv @@
package mpcs_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 16;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] POL_FCFS  = 3'd0;
  localparam logic [2:0] POL_RR    = 3'd1;
  localparam logic [2:0] POL_SJF   = 3'd2;
  localparam logic [2:0] POL_SRTF  = 3'd3;
  localparam logic [2:0] POL_NPRIO = 3'd4;
  localparam logic [2:0] POL_PPRIO = 3'd5;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SLICE  = 1'b1;

  localparam logic ACT_ADMIT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic [7:0]           id;
    logic [7:0]           burst;
    logic [7:0]           rest;
    logic [7:0]           prio;
    logic [TIME_BITS-1:0] arrival;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic step;
    logic insert;
    logic preempt;
    logic dispatch;
    logic run;
    logic finish_admit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_more;
    logic preempt_ok;
  } status_t;

  function automatic logic [2:0] eff_policy(logic [2:0] p);
    return (p > POL_PPRIO) ? POL_FCFS : p;
  endfunction

  // strict ordering: a goes ahead of b
  function automatic logic goes_before(entry_t a, entry_t b, logic [2:0] pol);
    logic [7:0] ka;
    logic [7:0] kb;
    ka = a.prio;
    kb = b.prio;
    if (pol == POL_FCFS || pol == POL_RR) begin
      return (a.arrival < b.arrival) || (a.arrival == b.arrival && a.id < b.id);
    end
    if (pol == POL_SJF) begin
      ka = a.burst;
      kb = b.burst;
    end else if (pol == POL_SRTF) begin
      ka = a.rest;
      kb = b.rest;
    end
    return (ka < kb) || (ka == kb && a.arrival < b.arrival);
  endfunction
endpackage

@@ hdl/mpcs_ctrl.sv @@
module mpcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             action,
  input  mpcs_pkg::status_t status,
  output mpcs_pkg::cmd_t    cmd,
  output logic             busy
);
  import mpcs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ADMIT  = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_INSERT = 7'b0001000,
    S_PRE    = 7'b0010000,
    S_DISP   = 7'b0100000,
    S_RUN    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   tick, tick_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick  <= 1'b0;
    end else begin
      state <= state_next;
      tick  <= tick_next;
    end
  end

  always_comb begin
    state_next = state;
    tick_next  = tick;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          tick_next  = (action == ACT_TICK);
          state_next = (action == ACT_TICK) ? S_PRE : S_ADMIT;
        end
      end
      S_ADMIT: begin
        if (status.full) begin
          cmd.finish_admit = 1'b1;
          state_next       = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_more) cmd.step = 1'b1;
        else state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        // a preempted job is back in the table; the new one already runs
        if (tick) begin
          state_next = S_RUN;
        end else begin
          cmd.finish_admit = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_PRE: begin
        if (status.preempt_ok) begin
          cmd.preempt = 1'b1;
          state_next  = S_SCAN;
        end else begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        state_next   = S_RUN;
      end
      S_RUN: begin
        cmd.run    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

@@ hdl/mpcs_datapath.sv @@
module mpcs_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mpcs_pkg::cmd_t     cmd,
  output mpcs_pkg::status_t  status,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        job_id,
  input  logic [7:0]        job_burst,
  input  logic [7:0]        job_priority,
  output logic              done,
  output logic              rejected,
  output logic [7:0]        run_id,
  output logic              finished,
  output logic [15:0]       turnaround,
  output logic [15:0]       wait_time
);
  import mpcs_pkg::*;

  logic [2:0]           policy;
  logic [7:0]           slice_length;
  entry_t               table_q [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  idx;
  entry_t               cand;
  entry_t               running;
  logic                 running_valid;
  logic [7:0]           slice_used;
  logic [TIME_BITS-1:0] current_time;

  logic [2:0]           pol;
  entry_t               scan_entry;
  logic                 full;

  // run-cycle results
  entry_t               run_upd;
  logic [7:0]           su_inc;
  logic                 run_fin;
  logic                 run_expire;
  logic [TIME_BITS-1:0] ta;
  logic [TIME_BITS-1:0] wt;

  assign pol        = eff_policy(policy);
  assign full       = (count >= CNT_BITS'(QUEUE_DEPTH));
  assign scan_entry = table_q[idx[IDX_BITS-1:0]];

  assign status.full       = full;
  assign status.scan_more  = (idx < count) && goes_before(scan_entry, cand, pol);
  assign status.preempt_ok = running_valid && (count != '0) &&
    ((pol == POL_SRTF && table_q[0].rest < running.rest) ||
     (pol == POL_PPRIO && table_q[0].prio < running.prio));

  always_comb begin
    run_upd      = running;
    run_upd.rest = (running.rest != 8'd0) ? running.rest - 8'd1 : 8'd0;
    su_inc       = (slice_used != 8'hFF) ? slice_used + 8'd1 : slice_used;
    run_fin      = running_valid && (run_upd.rest == 8'd0);
    run_expire   = running_valid && !run_fin && (pol == POL_RR) && (su_inc >= slice_length);
    ta           = current_time - running.arrival + TIME_BITS'(1);
    wt           = ta - TIME_BITS'(running.burst);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POL_FCFS;
      slice_length  <= 8'd2;
      count         <= '0;
      running_valid <= 1'b0;
      slice_used    <= 8'd0;
      current_time  <= '0;
      done          <= 1'b0;
    end else begin
      done <= cmd.finish_admit | cmd.run;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_POLICY: policy       <= cfg_data[2:0];
          REG_SLICE:  slice_length <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.latch) begin
        cand <= '{id: job_id, burst: job_burst, rest: job_burst,
                  prio: job_priority, arrival: current_time};
        idx  <= '0;
      end

      if (cmd.step) idx <= idx + CNT_BITS'(1);

      if (cmd.insert) begin
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (CNT_BITS'(i) > idx && CNT_BITS'(i) <= count) table_q[i] <= table_q[i-1];
        end
        table_q[idx[IDX_BITS-1:0]] <= cand;
        count <= count + CNT_BITS'(1);
      end

      // head removal shared by preempt and dispatch
      if (cmd.preempt || (cmd.dispatch && !running_valid && count != '0)) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) table_q[i] <= table_q[i+1];
        count         <= count - CNT_BITS'(1);
        running       <= table_q[0];
        running_valid <= 1'b1;
        slice_used    <= 8'd0;
      end
      if (cmd.preempt) begin
        cand <= running;
        idx  <= '0;
      end

      if (cmd.finish_admit) begin
        rejected   <= full;
        run_id     <= 8'd0;
        finished   <= 1'b0;
        turnaround <= 16'd0;
        wait_time  <= 16'd0;
      end

      if (cmd.run) begin
        rejected     <= 1'b0;
        run_id       <= running_valid ? running.id : 8'd0;
        finished     <= run_fin;
        turnaround   <= run_fin ? 16'(ta) : 16'd0;
        wait_time    <= run_fin ? 16'(wt) : 16'd0;
        current_time <= current_time + TIME_BITS'(1);
        if (running_valid) begin
          running    <= run_upd;
          slice_used <= su_inc;
          if (run_fin) begin
            running_valid <= 1'b0;
            slice_used    <= 8'd0;
          end else if (run_expire) begin
            if (!full) begin
              table_q[count[IDX_BITS-1:0]] <= run_upd;
              count         <= count + CNT_BITS'(1);
              running_valid <= 1'b0;
            end
            slice_used <= 8'd0;
          end
        end
      end
    end
  end
endmodule

@@ hdl/multi_policy_cpu_scheduler.sv @@
// Admit: ordered-insert scan from start to done, one entry/cycle; a full table rejects the job.
// Tick: preempt or dispatch, then run; a preempted job is reinserted by the scan before the run.
// One item at a time; a new start is taken once busy drops, the same cycle done shows.
// done is a one-cycle strobe; the receiver cannot stall.
// rst (sync, high): empty table, nothing running, time 0, policy FCFS, slice 2.
module multi_policy_cpu_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [7:0]  job_id,
  input  logic [7:0]  job_burst,
  input  logic [7:0]  job_priority,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic        rejected,
  output logic [7:0]  run_id,
  output logic        finished,
  output logic [15:0] turnaround,
  output logic [15:0] wait_time
);
  import mpcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  mpcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mpcs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .job_id       (job_id),
    .job_burst    (job_burst),
    .job_priority (job_priority),
    .done         (done),
    .rejected     (rejected),
    .run_id       (run_id),
    .finished     (finished),
    .turnaround   (turnaround),
    .wait_time    (wait_time)
  );
endmodule

@@ hdl/mpcs_checker.sv @@
`include "assert_macros.svh"
module mpcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        rejected,
  input logic [7:0]  run_id,
  input logic        finished,
  input logic [15:0] turnaround,
  input logic [15:0] wait_time
);
  // every transfer starts a sequence that raises busy
  `CHK_NEXT(a_take_busy, start && !busy, busy)
  // results land as the controller returns to idle
  `CHK_NOW(a_done_idle, done, !busy)
  // a refused admit carries no tick result
  `CHK_NOW(a_rej_clean, done && rejected, run_id == 8'd0 && !finished)
  // statistics only on completion
  `CHK_NOW(a_stats_zero, done && !finished, turnaround == 16'd0 && wait_time == 16'd0)
endmodule

bind multi_policy_cpu_scheduler mpcs_checker u_mpcs_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .rejected   (rejected),
  .run_id     (run_id),
  .finished   (finished),
  .turnaround (turnaround),
  .wait_time  (wait_time)
);
